// ----- hw/rtl/rsc_pkg.sv -----
// Shared types, codes and constants for the remote stick command conditioner.
package rsc_pkg;

    localparam int STICK_W    = 11;
    localparam int Q_W        = 32;
    localparam int MS_W       = 32;
    localparam int CODE_W     = 8;
    localparam int DZ_W       = 10;
    localparam int GAIN_W     = 24;
    localparam int DEB_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DT_W       = 8;

    // Default build constants
    localparam int YAW_STEP_DEF     = 6554;
    localparam int SHOT_HOLD_MS_DEF = 100;
    localparam int PITCH_MIN_DEF    = -1966080;
    localparam int PITCH_MAX_DEF    = 1966080;
    localparam int DT_CLAMP_MS_DEF  = 20;

    // Switch codes
    localparam logic [CODE_W-1:0] MODE_UPPER_UP   = 8'd0;
    localparam logic [CODE_W-1:0] MODE_LOWER_UP   = 8'd3;
    localparam logic [CODE_W-1:0] MODE_LOWER_DOWN = 8'd5;
    localparam logic [CODE_W-1:0] FIRE_FRIC_UP    = 8'd0;
    localparam logic [CODE_W-1:0] FIRE_TRIG_UP    = 8'd3;
    localparam logic [CODE_W-1:0] FIRE_TRIG_DOWN  = 8'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHASSIS_DZ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GIMBAL_DZ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SLEW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SLEW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd7;

    // Register reset values
    localparam logic [DZ_W-1:0]   CHASSIS_DZ_RST  = 10'd20;
    localparam logic [DZ_W-1:0]   GIMBAL_DZ_RST   = 10'd20;
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST = 24'd65;
    localparam logic [GAIN_W-1:0] SPIN_GAIN_RST   = 24'd65;
    localparam logic [GAIN_W-1:0] LINEAR_SLEW_RST = 24'd655;
    localparam logic [GAIN_W-1:0] SPIN_SLEW_RST   = 24'd655;
    localparam logic [GAIN_W-1:0] PITCH_GAIN_RST  = 24'd6;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = 16'd50;

    typedef enum logic [1:0] {
        TRIG_UP,
        TRIG_MID,
        TRIG_DOWN,
        TRIG_NONE
    } trig_pos_t;

    typedef enum logic [1:0] {
        FEED_IDLE,
        FEED_SINGLE,
        FEED_BURST
    } feed_mode_t;

    typedef struct packed {
        logic [DZ_W-1:0]          chassis_deadzone;
        logic [DZ_W-1:0]          gimbal_deadzone;
        logic [GAIN_W-1:0]        linear_gain;
        logic [GAIN_W-1:0]        spin_gain;
        logic [GAIN_W-1:0]        linear_slew_per_ms;
        logic [GAIN_W-1:0]        spin_slew_per_ms;
        logic signed [GAIN_W-1:0] pitch_gain;
        logic [DEB_W-1:0]         debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic                      link_online;
        logic [CODE_W-1:0]         mode_switch_code;
        logic [CODE_W-1:0]         fire_switch_code;
        logic signed [STICK_W-1:0] left_x;
        logic signed [STICK_W-1:0] left_y;
        logic signed [STICK_W-1:0] right_x;
        logic signed [STICK_W-1:0] right_y;
        logic [MS_W-1:0]           now_ms;
        logic                      feedback_valid;
        logic signed [Q_W-1:0]     yaw_feedback;
        logic signed [Q_W-1:0]     pitch_feedback;
    } item_t;

    typedef struct packed {
        logic                  stop_request;
        logic                  online_status;
        logic                  sd_up_mode;
        logic signed [Q_W-1:0] yaw_reference;
        logic signed [Q_W-1:0] pitch_reference;
        logic signed [Q_W-1:0] vx_command;
        logic signed [Q_W-1:0] vy_command;
        logic signed [Q_W-1:0] wz_command;
        logic                  fric_enable;
        feed_mode_t            feed_mode;
    } result_t;

    // Saturate a wide signed value to 32 bits signed
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi)
        begin
            sat32 = hi[Q_W-1:0];
        end
        else if (v < lo)
        begin
            sat32 = lo[Q_W-1:0];
        end
        else
        begin
            sat32 = v[Q_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/rsc_cfg_regs.sv -----
// Configuration register file for the remote stick command conditioner.
module rsc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rsc_pkg::cfg_t                    cfg
);
    import rsc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chassis_deadzone   <= CHASSIS_DZ_RST;
            cfg_reg.gimbal_deadzone    <= GIMBAL_DZ_RST;
            cfg_reg.linear_gain        <= LINEAR_GAIN_RST;
            cfg_reg.spin_gain          <= SPIN_GAIN_RST;
            cfg_reg.linear_slew_per_ms <= LINEAR_SLEW_RST;
            cfg_reg.spin_slew_per_ms   <= SPIN_SLEW_RST;
            cfg_reg.pitch_gain         <= PITCH_GAIN_RST;
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CHASSIS_DZ:  cfg_reg.chassis_deadzone   <= cfg_data[DZ_W-1:0];
                CFG_GIMBAL_DZ:   cfg_reg.gimbal_deadzone    <= cfg_data[DZ_W-1:0];
                CFG_LINEAR_GAIN: cfg_reg.linear_gain        <= cfg_data[GAIN_W-1:0];
                CFG_SPIN_GAIN:   cfg_reg.spin_gain          <= cfg_data[GAIN_W-1:0];
                CFG_LINEAR_SLEW: cfg_reg.linear_slew_per_ms <= cfg_data[GAIN_W-1:0];
                CFG_SPIN_SLEW:   cfg_reg.spin_slew_per_ms   <= cfg_data[GAIN_W-1:0];
                CFG_PITCH_GAIN:  cfg_reg.pitch_gain         <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_DEBOUNCE:    cfg_reg.debounce_ms        <= cfg_data[DEB_W-1:0];
                default:         cfg_reg                    <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/rsc_core.sv -----
// Single-pass conditioning logic and the per-poll state it carries.
module rsc_core
#(
    parameter int YAW_STEP     = rsc_pkg::YAW_STEP_DEF,
    parameter int SHOT_HOLD_MS = rsc_pkg::SHOT_HOLD_MS_DEF,
    parameter int PITCH_MIN    = rsc_pkg::PITCH_MIN_DEF,
    parameter int PITCH_MAX    = rsc_pkg::PITCH_MAX_DEF,
    parameter int DT_CLAMP_MS  = rsc_pkg::DT_CLAMP_MS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  rsc_pkg::item_t    item,
    input  rsc_pkg::cfg_t     cfg,
    output rsc_pkg::result_t  result
);
    import rsc_pkg::*;

    logic signed [Q_W-1:0] yaw_ref_reg;
    logic signed [Q_W-1:0] pitch_ref_reg;
    logic signed [Q_W-1:0] vx_reg;
    logic signed [Q_W-1:0] vy_reg;
    logic signed [Q_W-1:0] wz_reg;
    logic                  seeded_reg;
    logic [MS_W-1:0]       last_poll_reg;
    trig_pos_t             trig_last_reg;
    logic                  armed_reg;
    logic [MS_W-1:0]       change_ms_reg;
    logic [MS_W-1:0]       shot_until_reg;

    logic signed [Q_W-1:0] yaw_ref_next;
    logic signed [Q_W-1:0] pitch_ref_next;
    logic signed [Q_W-1:0] vx_next;
    logic signed [Q_W-1:0] vy_next;
    logic signed [Q_W-1:0] wz_next;
    logic                  seeded_next;
    logic [MS_W-1:0]       last_poll_next;
    trig_pos_t             trig_last_next;
    logic                  armed_next;
    logic [MS_W-1:0]       change_ms_next;
    logic [MS_W-1:0]       shot_until_next;

    logic                  seed;
    logic signed [Q_W-1:0] yaw_base;
    logic signed [Q_W-1:0] pitch_base;
    logic signed [Q_W:0]   yaw_sum;
    logic signed [34:0]    pitch_inc;
    logic signed [35:0]    pitch_sum;
    logic signed [Q_W-1:0] pitch_clamped;

    logic [STICK_W-1:0]    mag_lx;
    logic [STICK_W-1:0]    mag_ly;
    logic [STICK_W-1:0]    mag_rx;
    logic [STICK_W-1:0]    mag_ry;
    logic signed [STICK_W:0] ly_neg;
    logic signed [35:0]    prod_vx;
    logic signed [36:0]    prod_vy;
    logic signed [35:0]    prod_wz;
    logic signed [Q_W-1:0] tgt_vx;
    logic signed [Q_W-1:0] tgt_vy;
    logic signed [Q_W-1:0] tgt_wz;

    logic [MS_W-1:0]       dt_full;
    logic [DT_W-1:0]       dt;
    logic [Q_W-1:0]        md_lin;
    logic [Q_W-1:0]        md_spin;

    trig_pos_t             pos;
    logic                  armed_pre;
    logic                  trig_take;
    feed_mode_t            load;

    function automatic logic [STICK_W-1:0] magnitude(input logic signed [STICK_W-1:0] v);
        magnitude = v[STICK_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [Q_W-1:0] slew(input logic signed [Q_W-1:0] cur,
                                                  input logic signed [Q_W-1:0] tgt,
                                                  input logic [Q_W-1:0]        md);
        logic signed [Q_W+1:0] hi;
        logic signed [Q_W+1:0] lo;
        logic signed [Q_W+1:0] t;
        hi = (Q_W+2)'(cur) + $signed({2'b00, md});
        lo = (Q_W+2)'(cur) - $signed({2'b00, md});
        t  = (Q_W+2)'(tgt);
        if (t > hi)
        begin
            slew = hi[Q_W-1:0];
        end
        else if (t < lo)
        begin
            slew = lo[Q_W-1:0];
        end
        else
        begin
            slew = tgt;
        end
    endfunction

    // Reference seeding, yaw step and pitch integration
    assign seed       = !seeded_reg && item.feedback_valid;
    assign yaw_base   = seed ? item.yaw_feedback : yaw_ref_reg;
    assign pitch_base = seed ? item.pitch_feedback : pitch_ref_reg;

    always_comb
    begin
        yaw_sum = (Q_W+1)'(yaw_base);
        if (item.mode_switch_code == MODE_LOWER_UP)
        begin
            yaw_sum = (Q_W+1)'(yaw_base) + (Q_W+1)'(YAW_STEP);
        end
        else if (item.mode_switch_code == MODE_LOWER_DOWN)
        begin
            yaw_sum = (Q_W+1)'(yaw_base) - (Q_W+1)'(YAW_STEP);
        end
    end

    assign mag_ry    = magnitude(item.right_y);
    assign pitch_inc = 35'(cfg.pitch_gain) * 35'(item.right_y);

    always_comb
    begin
        pitch_sum = 36'(pitch_base);
        if (mag_ry >= {1'b0, cfg.gimbal_deadzone})
        begin
            pitch_sum = 36'(pitch_base) + 36'(pitch_inc);
        end
        if (pitch_sum < 36'(PITCH_MIN))
        begin
            pitch_clamped = Q_W'(PITCH_MIN);
        end
        else if (pitch_sum > 36'(PITCH_MAX))
        begin
            pitch_clamped = Q_W'(PITCH_MAX);
        end
        else
        begin
            pitch_clamped = pitch_sum[Q_W-1:0];
        end
    end

    // Chassis targets
    assign mag_lx  = magnitude(item.left_x);
    assign mag_ly  = magnitude(item.left_y);
    assign mag_rx  = magnitude(item.right_x);
    assign ly_neg  = -$signed({item.left_y[STICK_W-1], item.left_y});
    assign prod_vx = 36'($signed({1'b0, cfg.linear_gain})) * 36'(item.left_x);
    assign prod_vy = 37'($signed({1'b0, cfg.linear_gain})) * 37'(ly_neg);
    assign prod_wz = 36'($signed({1'b0, cfg.spin_gain})) * 36'(item.right_x);

    assign tgt_vx = (mag_lx >= {1'b0, cfg.chassis_deadzone}) ? sat32(40'(prod_vx)) : '0;
    assign tgt_vy = (mag_ly >= {1'b0, cfg.chassis_deadzone}) ? sat32(40'(prod_vy)) : '0;
    assign tgt_wz = (mag_rx >= {1'b0, cfg.chassis_deadzone}) ? sat32(40'(prod_wz)) : '0;

    // Elapsed time and slew budgets
    assign dt_full = (last_poll_reg == '0) ? '0 : (item.now_ms - last_poll_reg);
    assign dt      = (dt_full > MS_W'(DT_CLAMP_MS)) ? DT_W'(DT_CLAMP_MS) : dt_full[DT_W-1:0];
    assign md_lin  = Q_W'(cfg.linear_slew_per_ms) * Q_W'(dt);
    assign md_spin = Q_W'(cfg.spin_slew_per_ms) * Q_W'(dt);

    // Trigger switch: debounce, arm and single shot
    always_comb
    begin
        if (item.fire_switch_code >= FIRE_TRIG_UP && item.fire_switch_code <= FIRE_TRIG_DOWN)
        begin
            pos = trig_pos_t'(2'(item.fire_switch_code - FIRE_TRIG_UP));
        end
        else
        begin
            pos = TRIG_MID;
        end
    end

    assign armed_pre = (pos != TRIG_DOWN) || armed_reg;
    assign trig_take = (pos != trig_last_reg)
                       && ((item.now_ms - change_ms_reg) >= {16'b0, cfg.debounce_ms});

    always_comb
    begin
        // Offline: clear velocities, seeding and last trigger position, re-arm, keep references and poll time
        yaw_ref_next    = yaw_ref_reg;
        pitch_ref_next  = pitch_ref_reg;
        vx_next         = '0;
        vy_next         = '0;
        wz_next         = '0;
        seeded_next     = 1'b0;
        last_poll_next  = last_poll_reg;
        trig_last_next  = TRIG_NONE;
        armed_next      = 1'b1;
        change_ms_next  = change_ms_reg;
        shot_until_next = shot_until_reg;
        load            = FEED_IDLE;

        result                 = '0;
        result.stop_request    = 1'b1;
        result.feed_mode       = FEED_IDLE;

        if (item.link_online)
        begin
            yaw_ref_next   = sat32(40'(yaw_sum));
            pitch_ref_next = pitch_clamped;
            vx_next        = slew(vx_reg, tgt_vx, md_lin);
            vy_next        = slew(vy_reg, tgt_vy, md_lin);
            wz_next        = slew(wz_reg, tgt_wz, md_spin);
            seeded_next    = seeded_reg || item.feedback_valid;
            last_poll_next = item.now_ms;
            trig_last_next = trig_last_reg;
            armed_next     = armed_pre;

            if (trig_take)
            begin
                change_ms_next = item.now_ms;
                trig_last_next = pos;
                if (pos == TRIG_DOWN && armed_pre)
                begin
                    shot_until_next = item.now_ms + MS_W'(SHOT_HOLD_MS);
                    armed_next      = 1'b0;
                end
            end

            priority if (item.now_ms < shot_until_next)
            begin
                load = FEED_SINGLE;
            end
            else if (pos == TRIG_UP)
            begin
                load = FEED_BURST;
            end
            else
            begin
                load = FEED_IDLE;
            end

            result.stop_request    = 1'b0;
            result.online_status   = 1'b1;
            result.sd_up_mode      = (item.mode_switch_code == MODE_UPPER_UP);
            result.yaw_reference   = yaw_ref_next;
            result.pitch_reference = pitch_ref_next;
            result.vx_command      = vx_next;
            result.vy_command      = vy_next;
            result.wz_command      = wz_next;
            result.fric_enable     = (item.fire_switch_code == FIRE_FRIC_UP);
            result.feed_mode       = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_ref_reg    <= '0;
            pitch_ref_reg  <= '0;
            vx_reg         <= '0;
            vy_reg         <= '0;
            wz_reg         <= '0;
            seeded_reg     <= 1'b0;
            last_poll_reg  <= '0;
            trig_last_reg  <= TRIG_NONE;
            armed_reg      <= 1'b1;
            change_ms_reg  <= '0;
            shot_until_reg <= '0;
        end
        else if (advance)
        begin
            yaw_ref_reg    <= yaw_ref_next;
            pitch_ref_reg  <= pitch_ref_next;
            vx_reg         <= vx_next;
            vy_reg         <= vy_next;
            wz_reg         <= wz_next;
            seeded_reg     <= seeded_next;
            last_poll_reg  <= last_poll_next;
            trig_last_reg  <= trig_last_next;
            armed_reg      <= armed_next;
            change_ms_reg  <= change_ms_next;
            shot_until_reg <= shot_until_next;
        end
    end

endmodule

// ----- hw/rtl/remote_stick_command_conditioner_top.sv -----
// Remote stick command conditioner: one conditioned command beat per remote poll beat.
// Each accepted poll lands in an input register; when it advances, the conditioning logic
// updates the carried state (references, velocities, poll time, trigger) and loads the
// result register, which then stays valid until it is accepted. One poll is
// accepted every cycle; the loop that sets this is the state update in the core, and a
// held result only stalls the input once both registers are full.
// Configuration writes are always ready and must be issued while no poll is in flight.
// Offline polls give stop_request with every other field zero.
module remote_stick_command_conditioner_top
#(
    parameter int YAW_STEP     = rsc_pkg::YAW_STEP_DEF,
    parameter int SHOT_HOLD_MS = rsc_pkg::SHOT_HOLD_MS_DEF,
    parameter int PITCH_MIN    = rsc_pkg::PITCH_MIN_DEF,
    parameter int PITCH_MAX    = rsc_pkg::PITCH_MAX_DEF,
    parameter int DT_CLAMP_MS  = rsc_pkg::DT_CLAMP_MS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                link_online,
    input  logic [rsc_pkg::CODE_W-1:0]          mode_switch_code,
    input  logic [rsc_pkg::CODE_W-1:0]          fire_switch_code,
    input  logic signed [rsc_pkg::STICK_W-1:0]  left_x,
    input  logic signed [rsc_pkg::STICK_W-1:0]  left_y,
    input  logic signed [rsc_pkg::STICK_W-1:0]  right_x,
    input  logic signed [rsc_pkg::STICK_W-1:0]  right_y,
    input  logic [rsc_pkg::MS_W-1:0]            now_ms,
    input  logic                                feedback_valid,
    input  logic signed [rsc_pkg::Q_W-1:0]      yaw_feedback,
    input  logic signed [rsc_pkg::Q_W-1:0]      pitch_feedback,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                stop_request,
    output logic                                online_status,
    output logic                                sd_up_mode,
    output logic signed [rsc_pkg::Q_W-1:0]      yaw_reference,
    output logic signed [rsc_pkg::Q_W-1:0]      pitch_reference,
    output logic signed [rsc_pkg::Q_W-1:0]      vx_command,
    output logic signed [rsc_pkg::Q_W-1:0]      vy_command,
    output logic signed [rsc_pkg::Q_W-1:0]      wz_command,
    output logic                                fric_enable,
    output logic [1:0]                          feed_mode
);
    import rsc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    rsc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held poll when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.link_online      <= link_online;
            in_item_reg.mode_switch_code <= mode_switch_code;
            in_item_reg.fire_switch_code <= fire_switch_code;
            in_item_reg.left_x           <= left_x;
            in_item_reg.left_y           <= left_y;
            in_item_reg.right_x          <= right_x;
            in_item_reg.right_y          <= right_y;
            in_item_reg.now_ms           <= now_ms;
            in_item_reg.feedback_valid   <= feedback_valid;
            in_item_reg.yaw_feedback     <= yaw_feedback;
            in_item_reg.pitch_feedback   <= pitch_feedback;
        end
    end

    rsc_core
    #(
        .YAW_STEP     (YAW_STEP),
        .SHOT_HOLD_MS (SHOT_HOLD_MS),
        .PITCH_MIN    (PITCH_MIN),
        .PITCH_MAX    (PITCH_MAX),
        .DT_CLAMP_MS  (DT_CLAMP_MS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stop_request    = out_reg.stop_request;
    assign online_status   = out_reg.online_status;
    assign sd_up_mode      = out_reg.sd_up_mode;
    assign yaw_reference   = out_reg.yaw_reference;
    assign pitch_reference = out_reg.pitch_reference;
    assign vx_command      = out_reg.vx_command;
    assign vy_command      = out_reg.vy_command;
    assign wz_command      = out_reg.wz_command;
    assign fric_enable     = out_reg.fric_enable;
    assign feed_mode       = 2'(out_reg.feed_mode);

endmodule
